>>> src/wjcsr_pkg.sv
// ----------------------------------------------------------------------------
// wjcsr_pkg
// shared types and constants of the weighted jacobi csr row block
// ----------------------------------------------------------------------------
package wjcsr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_FRAC = 16;
    localparam int WEIGHT_W    = 18;
    localparam int ROW_W       = 16;
    localparam int VAL_W       = 32;
    localparam int ACC_W       = 64;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 18'd43691;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // one finished row as handed from front to back
    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic signed [ACC_W-1:0] sum;
        logic signed [VAL_W-1:0] diag;
        logic signed [VAL_W-1:0] rhs;
        logic signed [VAL_W-1:0] xrow;
    } row_job_t;

    // one result item
    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic signed [VAL_W-1:0] xnew;
        logic                    upd;
        logic                    sat;
    } row_res_t;

    // saturating signed 64-bit add
    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W-1:0] s;
        s = a + b;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1])
        begin
            s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return s;
    endfunction

endpackage

>>> src/wjcsr_front.sv
// ----------------------------------------------------------------------------
// wjcsr_front
// accumulates the entries of a row and hands finished rows to the queue
// ----------------------------------------------------------------------------
module wjcsr_front
    import wjcsr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic [ROW_W-1:0]        row_index,
    input  logic [ROW_W-1:0]        col_index,
    input  logic signed [VAL_W-1:0] entry_value,
    input  logic signed [VAL_W-1:0] x_at_col,
    input  logic signed [VAL_W-1:0] rhs_value,
    input  logic signed [VAL_W-1:0] x_at_row,
    input  logic                    entry_present,
    input  logic                    last_in_row,
    output logic                    job_valid,
    output row_job_t                job
);

    // stage 1: register the product so the add stands alone
    logic                    s1_valid_reg;
    logic                    s1_diag_reg;
    logic                    s1_prod_reg;
    logic                    s1_last_reg;
    logic signed [ACC_W-1:0] s1_term_reg;
    logic signed [VAL_W-1:0] s1_a_reg;
    logic [ROW_W-1:0]        s1_row_reg;
    logic signed [VAL_W-1:0] s1_rhs_reg;
    logic signed [VAL_W-1:0] s1_xr_reg;
    logic signed [ACC_W-1:0] prod;

    assign prod = entry_value * x_at_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diag_reg <= entry_present && (row_index == col_index);
        s1_prod_reg <= entry_present && (row_index != col_index);
        s1_last_reg <= last_in_row;
        s1_term_reg <= prod >>> FRAC_BITS;
        s1_a_reg    <= entry_value;
        s1_row_reg  <= row_index;
        s1_rhs_reg  <= rhs_value;
        s1_xr_reg   <= x_at_row;
    end

    // stage 2: running sum and diagonal
    logic signed [ACC_W-1:0] sum_reg, sum_next;
    logic signed [VAL_W-1:0] diag_reg, diag_next;

    always_comb
    begin
        sum_next  = sum_reg;
        diag_next = diag_reg;
        if (s1_prod_reg)
        begin
            sum_next = sat_add(sum_reg, s1_term_reg);
        end
        if (s1_diag_reg)
        begin
            diag_next = s1_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            diag_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            sum_reg  <= s1_last_reg ? '0 : sum_next;
            diag_reg <= s1_last_reg ? '0 : diag_next;
        end
    end

    // finished row
    assign job_valid = s1_valid_reg && s1_last_reg;
    assign job.row   = s1_row_reg;
    assign job.sum   = sum_next;
    assign job.diag  = diag_next;
    assign job.rhs   = s1_rhs_reg;
    assign job.xrow  = s1_xr_reg;

endmodule

>>> src/wjcsr_back.sv
// ----------------------------------------------------------------------------
// wjcsr_back
// restoring divider and weighting of one row job at a time
// ----------------------------------------------------------------------------
module wjcsr_back
    import wjcsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [WEIGHT_W-1:0]   weight,
    input  logic                  job_valid,
    input  row_job_t              job,
    output logic                  job_ready,
    output logic                  res_valid,
    output row_res_t              res,
    input  logic                  res_ready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // quotient bits: 64 integer bits plus FRAC_BITS fraction bits
    localparam int QB    = ACC_W + FRAC_BITS;
    localparam int CNT_W = $clog2(QB + 1);

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [ACC_W-1:0]        rem_reg;
    logic [QB-1:0]           num_reg;
    logic [QB-1:0]           quo_reg;
    logic [VAL_W-1:0]        den_reg;
    logic                    neg_reg;
    logic                    zero_reg;
    logic [ROW_W-1:0]        row_reg;
    logic signed [VAL_W-1:0] xr_reg;
    logic                    sat_reg;
    logic signed [51:0]      p1_reg;
    logic signed [51:0]      p2_reg;
    row_res_t                res_reg;

    // job decode
    logic signed [ACC_W-1:0] num;
    logic [ACC_W-1:0]        nmag;
    logic [VAL_W-1:0]        dmag;
    logic signed [ACC_W:0]   numw;

    always_comb
    begin
        numw = {job.rhs[VAL_W-1], {(ACC_W-VAL_W){job.rhs[VAL_W-1]}}, job.rhs}
             - {job.sum[ACC_W-1], job.sum};
        if (numw[ACC_W] != numw[ACC_W-1])
        begin
            num = numw[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        else
        begin
            num = numw[ACC_W-1:0];
        end
        nmag = num[ACC_W-1] ? (~num + 1'b1) : num;
        dmag = job.diag[VAL_W-1] ? (~job.diag + 1'b1) : job.diag;
    end

    // one restoring step
    logic [ACC_W:0] trial;
    assign trial = {rem_reg, num_reg[QB-1]} - {{(ACC_W+1-VAL_W){1'b0}}, den_reg};

    // quotient check: the signed integer part must stay within -2^(31-FRAC_BITS) .. 2^(31-FRAC_BITS)-1
    logic [VAL_W:0]  qmag;
    logic            qbig;
    logic [QB-1:0]   qtop_mask;
    assign qtop_mask = {{(QB-VAL_W){1'b1}}, {VAL_W{1'b0}}};
    assign qbig      = |(quo_reg & qtop_mask);
    assign qmag      = {1'b0, quo_reg[VAL_W-1:0]};

    logic signed [VAL_W:0]  qs;
    logic signed [VAL_W-1:0] qclip;
    logic                    qsat;
    always_comb
    begin
        qs = neg_reg ? -$signed(qmag) : $signed(qmag);
        qsat  = 1'b0;
        qclip = qs[VAL_W-1:0];
        if (qbig || qs > $signed({2'b00, {(VAL_W-1){1'b1}}}) ||
            qs < $signed({2'b11, {(VAL_W-1){1'b0}}}))
        begin
            qsat  = 1'b1;
            qclip = neg_reg ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // weighting sum and clip
    logic signed [53:0] acc;
    logic signed [37:0] shifted;
    logic signed [VAL_W-1:0] xclip;
    logic                    xsat;
    always_comb
    begin
        acc = 54'(p1_reg) + 54'(p2_reg) + 54'(1 << (WEIGHT_FRAC - 1));
        shifted = 38'(acc >>> WEIGHT_FRAC);
        xsat  = 1'b0;
        xclip = shifted[VAL_W-1:0];
        if (shifted > $signed({7'd0, {(VAL_W-1){1'b1}}}))
        begin
            xsat = 1'b1;
            xclip = {1'b0, {(VAL_W-1){1'b1}}};
        end
        else if (shifted < $signed({7'h7f, {(VAL_W-1){1'b0}}}))
        begin
            xsat = 1'b1;
            xclip = {1'b1, {(VAL_W-1){1'b0}}};
        end
    end

    logic signed [19:0] one_minus_w;
    assign one_minus_w = 20'sd65536 - $signed({2'b00, weight});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (job_valid) state_next = (job.diag == '0) ? ST_OUT : ST_DIV;
            ST_DIV:  if (cnt_reg == CNT_W'(QB - 1)) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT:  if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cnt_reg  <= '0;
                rem_reg  <= '0;
                num_reg  <= {nmag, {FRAC_BITS{1'b0}}};
                den_reg  <= dmag;
                neg_reg  <= num[ACC_W-1] ^ job.diag[VAL_W-1];
                zero_reg <= (job.diag == '0);
                row_reg  <= job.row;
                xr_reg   <= job.xrow;
                res_reg.row  <= job.row;
                res_reg.xnew <= job.xrow;
                res_reg.upd  <= 1'b0;
                res_reg.sat  <= 1'b0;
            end
            ST_DIV:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                num_reg <= {num_reg[QB-2:0], 1'b0};
                if (!trial[ACC_W])
                begin
                    rem_reg <= trial[ACC_W-1:0];
                    quo_reg <= {quo_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[ACC_W-2:0], num_reg[QB-1]};
                    quo_reg <= {quo_reg[QB-2:0], 1'b0};
                end
            end
            ST_MUL:
            begin
                sat_reg <= qsat;
                p1_reg  <= 52'(one_minus_w * xr_reg);
                p2_reg  <= 52'($signed({1'b0, weight}) * qclip);
            end
            ST_SUM:
            begin
                res_reg.row  <= row_reg;
                res_reg.xnew <= xclip;
                res_reg.upd  <= 1'b1;
                res_reg.sat  <= sat_reg | xsat;
            end
            default:
            begin
            end
        endcase
    end

    assign job_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);
    assign res       = res_reg;

    // a zero diagonal never produces an updated result
    a_zero_no_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && zero_reg) |-> !res.upd) else $error("zero diag updated");
    // result held while receiver stalls
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res))) else $error("result moved");
    // a job with a nonzero diagonal that is taken starts the division
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && job_valid && job.diag != '0) |=> (state_reg == ST_DIV))
        else $error("divider not started");

endmodule

>>> src/wjcsr_queue.sv
// ----------------------------------------------------------------------------
// wjcsr_queue
// short queue of row jobs between front and back
// ----------------------------------------------------------------------------
module wjcsr_queue
    import wjcsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  row_job_t wr_data,
    output logic     rd_valid,
    output row_job_t rd_data,
    input  logic     rd_en,
    output logic     room
);

    row_job_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en && rd_valid) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{QPTR_W{1'b0}}, wr_en}
                     - {{QPTR_W{1'b0}}, (rd_en && rd_valid)};
        end
    end

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    // two slots kept for items already inside the front pipeline
    assign room     = (cnt_reg < (QPTR_W+1)'(QDEPTH - 2));

endmodule

>>> src/weighted_jacobi_csr_row_top.sv
// ----------------------------------------------------------------------------
// weighted_jacobi_csr_row_top
// weighted jacobi relaxation of one csr row, streamed one entry per item
// ----------------------------------------------------------------------------
// usage
//   input queue: push an item while full is low; one item per stored entry of
//   a row, last_in_row set on the final one (entry_present low for an empty row)
//   result queue: while empty is low the result is on out_row, x_new, updated
//   and saturated; pop takes it. one result per row.
//   weight: write relax_weight via cfg_valid/cfg_ready while the block is idle.
// timing
//   the front takes one item per cycle while full is low; a row's result
//   passes the front stage, the queue, the load, the bit-serial divider (80
//   quotient steps) and the weighting and sum stages; it can be popped on
//   the next edge. the back takes one row at a time (a zero diagonal or
//   empty row skips the divider); once two finished rows wait, full is raised.
// reset
//   clears sums, queue and divider control; the weight register returns to 43691.
//   a stalled receiver holds the result and in turn fills the queue.
// ----------------------------------------------------------------------------
module weighted_jacobi_csr_row_top
    import wjcsr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [WEIGHT_W-1:0]     relax_weight,
    input  logic                    push,
    output logic                    full,
    input  logic [ROW_W-1:0]        row_index,
    input  logic [ROW_W-1:0]        col_index,
    input  logic signed [VAL_W-1:0] entry_value,
    input  logic signed [VAL_W-1:0] x_at_col,
    input  logic signed [VAL_W-1:0] rhs_value,
    input  logic signed [VAL_W-1:0] x_at_row,
    input  logic                    entry_present,
    input  logic                    last_in_row,
    output logic                    empty,
    input  logic                    pop,
    output logic [ROW_W-1:0]        out_row,
    output logic signed [VAL_W-1:0] x_new,
    output logic                    updated,
    output logic                    saturated
);

    logic [WEIGHT_W-1:0] weight_reg;
    logic                take, job_valid, q_valid, q_pop, room, res_valid;
    row_job_t            job, q_job;
    row_res_t            res;

    // weight register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            weight_reg <= relax_weight;
        end
    end
    assign cfg_ready = 1'b1;

    assign full = !room;
    assign take = push && room;

    wjcsr_front u_front (
        .clk(clk), .rst_n(rst_n), .take(take),
        .row_index(row_index), .col_index(col_index), .entry_value(entry_value),
        .x_at_col(x_at_col), .rhs_value(rhs_value), .x_at_row(x_at_row),
        .entry_present(entry_present), .last_in_row(last_in_row),
        .job_valid(job_valid), .job(job)
    );

    wjcsr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(job_valid), .wr_data(job),
        .rd_valid(q_valid), .rd_data(q_job), .rd_en(q_pop), .room(room)
    );

    wjcsr_back u_back (
        .clk(clk), .rst_n(rst_n), .weight(weight_reg),
        .job_valid(q_valid), .job(q_job), .job_ready(q_pop),
        .res_valid(res_valid), .res(res), .res_ready(pop)
    );

    assign empty     = !res_valid;
    assign out_row   = res.row;
    assign x_new     = res.xnew;
    assign updated   = res.upd;
    assign saturated = res.sat;

endmodule
